@@ sv/graph_scatter_reduce_unit_assert.svh @@
`ifndef GRAPH_SCATTER_REDUCE_UNIT_ASSERT_SVH
`define GRAPH_SCATTER_REDUCE_UNIT_ASSERT_SVH

// Checks a property on the rising clock edge outside reset.
`define GSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define GSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/gsr_pkg.sv @@
package gsr_pkg;

  localparam int unsigned IN_LANES  = 4;
  localparam int unsigned NODE_W    = 10;
  localparam int unsigned LANE_W    = 32;
  localparam int unsigned COUNT_W   = 16;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_EDGE  = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] MODE_SUM  = 2'd0;
  localparam logic [1:0] MODE_MEAN = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;
  localparam logic [1:0] MODE_MAX  = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_EDGE,
    OP_DRAIN,
    OP_DRAIN_OOR,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_DRAIN_RD,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT,
    ST_CLEAR
  } back_state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [9:0]        src_node;
    logic [9:0]        dst_node;
    logic signed [31:0] lane0_in;
    logic signed [31:0] lane1_in;
    logic signed [31:0] lane2_in;
    logic signed [31:0] lane3_in;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         row_node;
    logic signed [31:0] lane0_out;
    logic signed [31:0] lane1_out;
    logic signed [31:0] lane2_out;
    logic signed [31:0] lane3_out;
    logic [15:0]        edge_count;
  } out_word_t;

  typedef struct packed {
    op_e                                op;
    logic [NODE_W-1:0]                  src_node;
    logic [NODE_W-1:0]                  dst_node;
    logic [IN_LANES-1:0][LANE_W-1:0]    lanes;
  } q_entry_t;

endpackage

@@ sv/graph_scatter_reduce_unit.sv @@
// Graph scatter-reduce unit: load words fill a source row store, edge words reduce a source
// row into a destination accumulator row (sum, mean, min or max by pool_mode), drain words
// return one row with its saturating edge count, and clear words zero all accumulators. A
// two-entry queue separates the input classifier from the executing back end. A load writes
// the source store as it is popped, an edge reads the accumulator memory and then writes it,
// and a drain reads the row (a node out of range skips the read) and, in mean mode with a
// nonzero count, divides each lane in turn with a one-bit-per-cycle divider before the output
// register takes it; a stalled output holds the back end. A clear sweeps the accumulator
// memory one row a cycle; the same sweep runs after reset, and no word is taken from the queue meanwhile.
module graph_scatter_reduce_unit import gsr_pkg::*; #(
  parameter int unsigned NODES      = 1024,
  parameter int unsigned FEAT_LANES = 4,
  parameter int unsigned OUT_NODES  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] mode_q;
  logic       q_valid, q_pop;
  q_entry_t   q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'b0, mode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SUM;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      mode_q <= pwdata[1:0];
    end
  end

  gsr_front #(.NODES(NODES), .OUT_NODES(OUT_NODES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_valid_o  (q_valid),
    .q_head_o   (q_head),
    .q_pop_i    (q_pop)
  );

  gsr_back #(.NODES(NODES), .FEAT_LANES(FEAT_LANES), .OUT_NODES(OUT_NODES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ sv/gsr_ram.sv @@
module gsr_ram import gsr_pkg::*; #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/gsr_front.sv @@
module gsr_front import gsr_pkg::*; #(
  parameter int unsigned NODES     = 1024,
  parameter int unsigned OUT_NODES = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  output logic     q_valid_o,
  output q_entry_t q_head_o,
  input  logic     q_pop_i
);

  q_entry_t   entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       src_ok, dst_ok, keep, push, pop;
  q_entry_t   cls;

  assign src_ok = 32'(in_word_i.src_node) < NODES;
  assign dst_ok = 32'(in_word_i.dst_node) < OUT_NODES;

  always_comb begin
    cls.src_node = in_word_i.src_node;
    cls.dst_node = in_word_i.dst_node;
    cls.lanes    = {in_word_i.lane3_in, in_word_i.lane2_in,
                    in_word_i.lane1_in, in_word_i.lane0_in};
    cls.op       = OP_CLEAR;
    keep         = 1'b1;
    case (in_word_i.cmd)
      CMD_LOAD: begin
        cls.op = OP_LOAD;
        keep   = src_ok;
      end
      CMD_EDGE: begin
        cls.op = OP_EDGE;
        keep   = src_ok && dst_ok;
      end
      CMD_DRAIN: begin
        cls.op = dst_ok ? OP_DRAIN : OP_DRAIN_OOR;
      end
      default: begin
        cls.op = OP_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o && keep;
  assign pop        = q_pop_i && (count_q != 2'd0);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_head_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls;
    end
  end

endmodule

@@ sv/gsr_div.sv @@
module gsr_div import gsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [LANE_W-1:0]  dividend_i,
  input  logic [COUNT_W-1:0] divisor_i,
  output logic               done_o,
  output logic [LANE_W-1:0]  quot_o
);

  localparam int unsigned STEP_W = $clog2(LANE_W);

  logic               busy_q, done_q;
  logic [STEP_W-1:0]  step_q;
  logic [COUNT_W-1:0] rem_q, div_q;
  logic [LANE_W-1:0]  quo_q;
  logic               neg_q;
  logic [COUNT_W:0]   shifted, trial;
  logic               fits;

  assign shifted = {rem_q, quo_q[LANE_W-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(LANE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[LANE_W-1];
      quo_q <= dividend_i[LANE_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo_q <= {quo_q[LANE_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -quo_q : quo_q;

endmodule

@@ sv/gsr_back.sv @@
module gsr_back import gsr_pkg::*; #(
  parameter int unsigned NODES      = 1024,
  parameter int unsigned FEAT_LANES = 4,
  parameter int unsigned OUT_NODES  = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] mode_i,
  input  logic       q_valid_i,
  input  q_entry_t   q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  localparam int unsigned LU    = (FEAT_LANES < IN_LANES) ? FEAT_LANES : IN_LANES;
  localparam int unsigned SAW   = $clog2(NODES);
  localparam int unsigned OAW   = $clog2(OUT_NODES);
  localparam int unsigned ROW_W = LU * LANE_W;
  localparam int unsigned LIW   = (LU > 1) ? $clog2(LU) : 1;

  back_state_e state_q, state_d;

  q_entry_t                  cur_q;
  logic [LU-1:0][LANE_W-1:0] row_q;
  logic [COUNT_W-1:0]        cnt_q;
  logic [LIW-1:0]            lane_q;
  logic [OAW-1:0]            clr_idx_q;
  logic                      out_valid_q;
  out_word_t                 out_word_q;

  logic                      src_we, acc_we;
  logic [SAW-1:0]            src_waddr, src_raddr;
  logic [ROW_W-1:0]          src_rdata;
  logic [OAW-1:0]            acc_waddr, acc_raddr;
  logic [ROW_W+COUNT_W-1:0]  acc_wdata, acc_rdata;
  logic [LU-1:0][LANE_W-1:0] src_row, acc_row, new_row;
  logic [COUNT_W-1:0]        acc_cnt, new_cnt;
  logic                      div_start, div_done, out_load, pop;
  logic [LANE_W-1:0]         div_quot;
  logic [IN_LANES-1:0][LANE_W-1:0] lanes_full;

  assign pop     = (state_q == ST_IDLE) && q_valid_i;
  assign q_pop_o = pop;

  assign src_we    = pop && (q_head_i.op == OP_LOAD);
  assign src_waddr = SAW'(q_head_i.src_node);
  assign src_raddr = SAW'(q_head_i.src_node);
  assign acc_raddr = OAW'(q_head_i.dst_node);

  gsr_ram #(.WIDTH(ROW_W), .DEPTH(NODES)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (q_head_i.lanes[LU-1:0]),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  gsr_ram #(.WIDTH(ROW_W + COUNT_W), .DEPTH(OUT_NODES)) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (acc_we),
    .waddr_i (acc_waddr),
    .wdata_i (acc_wdata),
    .raddr_i (acc_raddr),
    .rdata_o (acc_rdata)
  );

  assign src_row = src_rdata;
  assign acc_row = acc_rdata[ROW_W+COUNT_W-1:COUNT_W];
  assign acc_cnt = acc_rdata[COUNT_W-1:0];
  assign new_cnt = (acc_cnt == COUNT_MAX) ? acc_cnt : acc_cnt + 1'b1;

  always_comb begin
    for (int k = 0; k < LU; k++) begin
      case (mode_i)
        MODE_SUM, MODE_MEAN: new_row[k] = acc_row[k] + src_row[k];
        MODE_MIN: begin
          new_row[k] = (acc_cnt == '0 || $signed(src_row[k]) < $signed(acc_row[k]))
                       ? src_row[k] : acc_row[k];
        end
        default: begin
          new_row[k] = (acc_cnt == '0 || $signed(src_row[k]) > $signed(acc_row[k]))
                       ? src_row[k] : acc_row[k];
        end
      endcase
    end
  end

  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = OAW'(cur_q.dst_node);
    acc_wdata = {new_row, new_cnt};
    if (state_q == ST_EDGE_WR) begin
      acc_we = 1'b1;
    end else if (state_q == ST_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_idx_q;
      acc_wdata = '0;
    end
  end

  gsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (row_q[lane_q]),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign div_start = (state_q == ST_DIV_GO);
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (q_head_i.op)
            OP_EDGE:      state_d = ST_EDGE_WR;
            OP_DRAIN:     state_d = ST_DRAIN_RD;
            OP_DRAIN_OOR: state_d = ST_OUT;
            OP_CLEAR:     state_d = ST_CLEAR;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE_WR: state_d = ST_IDLE;
      ST_DRAIN_RD: begin
        if (acc_cnt != '0 && mode_i == MODE_MEAN) begin
          state_d = ST_DIV_GO;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (lane_q == LIW'(LU - 1)) ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_idx_q == OAW'(OUT_NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end else begin
        clr_idx_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    lanes_full = '0;
    for (int k = 0; k < LU; k++) begin
      lanes_full[k] = row_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_head_i;
      row_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == ST_DRAIN_RD) begin
      cnt_q  <= acc_cnt;
      row_q  <= (acc_cnt == '0) ? '0 : acc_row;
      lane_q <= '0;
    end
    if (state_q == ST_DIV_WAIT && div_done) begin
      row_q[lane_q] <= div_quot;
      lane_q        <= lane_q + 1'b1;
    end
    if (out_load) begin
      out_word_q.row_node   <= cur_q.dst_node;
      out_word_q.lane0_out  <= lanes_full[0];
      out_word_q.lane1_out  <= lanes_full[1];
      out_word_q.lane2_out  <= lanes_full[2];
      out_word_q.lane3_out  <= lanes_full[3];
      out_word_q.edge_count <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`include "graph_scatter_reduce_unit_assert.svh"

  `GSR_ASSERT(a_no_pop_in_clear, (state_q == ST_CLEAR) |-> !q_pop_o, "pop during clear sweep")
  `GSR_ASSERT(a_edge_count_nonzero, (state_q == ST_EDGE_WR) |-> (new_cnt != '0), "edge count zero after edge")
  `GSR_ASSERT(a_div_done_waiting, div_done |-> (state_q == ST_DIV_WAIT), "divider done outside wait")
  `GSR_ASSERT_ALWAYS(a_load_only_from_out, out_load |-> (state_q == ST_OUT), "result loaded outside output state")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import gsr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  graph_scatter_reduce_unit DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] src_rows [1024][4];
  logic [31:0] acc_rows [1024][4];
  logic [15:0] edge_cnt [1024];
  bit          loaded   [1024];
  int          loaded_nodes[$];
  logic [1:0]  pool_mode;
  out_word_t   drain_rows[$];

  int errors = 0;
  int words_sent = 0;
  int rows_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic void aggregate(in_word_t w);
    logic [31:0] lanes [4];
    logic [31:0] s;
    logic [31:0] a;
    out_word_t   r;
    bit          first;
    lanes = '{w.lane0_in, w.lane1_in, w.lane2_in, w.lane3_in};
    case (w.cmd)
      CMD_LOAD: begin
        for (int k = 0; k < 4; k++) src_rows[w.src_node][k] = lanes[k];
        if (!loaded[w.src_node]) loaded_nodes.push_back(int'(w.src_node));
        loaded[w.src_node] = 1'b1;
      end
      CMD_EDGE: begin
        first = (edge_cnt[w.dst_node] == 0);
        for (int k = 0; k < 4; k++) begin
          s = src_rows[w.src_node][k];
          a = acc_rows[w.dst_node][k];
          if (pool_mode == MODE_SUM || pool_mode == MODE_MEAN) a = a + s;
          else if (first) a = s;
          else if (pool_mode == MODE_MIN) begin
            if ($signed(s) < $signed(a)) a = s;
          end else if ($signed(s) > $signed(a)) a = s;
          acc_rows[w.dst_node][k] = a;
        end
        if (edge_cnt[w.dst_node] != COUNT_MAX) edge_cnt[w.dst_node]++;
      end
      CMD_CLEAR: begin
        for (int n = 0; n < 1024; n++) begin
          edge_cnt[n] = '0;
          for (int k = 0; k < 4; k++) acc_rows[n][k] = '0;
        end
      end
      default: begin
        r = '0;
        r.row_node = w.dst_node;
        r.edge_count = edge_cnt[w.dst_node];
        if (r.edge_count != 0) begin
          for (int k = 0; k < 4; k++) begin
            a = acc_rows[w.dst_node][k];
            if (pool_mode == MODE_MEAN)
              a = 32'(longint'($signed(a)) / longint'(r.edge_count));
            lanes[k] = a;
          end
          r.lane0_out = lanes[0];
          r.lane1_out = lanes[1];
          r.lane2_out = lanes[2];
          r.lane3_out = lanes[3];
        end
        drain_rows.push_back(r);
      end
    endcase
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (drain_rows.size() == 0) begin
        report("unexpected word", 32'(out_word_o.row_node), '0);
      end else begin
        want = drain_rows.pop_front();
        rows_checked++;
        if (out_word_o.row_node != want.row_node)
          report("row_node", 32'(out_word_o.row_node), 32'(want.row_node));
        if (out_word_o.lane0_out != want.lane0_out)
          report("lane0_out", out_word_o.lane0_out, want.lane0_out);
        if (out_word_o.lane1_out != want.lane1_out)
          report("lane1_out", out_word_o.lane1_out, want.lane1_out);
        if (out_word_o.lane2_out != want.lane2_out)
          report("lane2_out", out_word_o.lane2_out, want.lane2_out);
        if (out_word_o.lane3_out != want.lane3_out)
          report("lane3_out", out_word_o.lane3_out, want.lane3_out);
        if (out_word_o.edge_count != want.edge_count)
          report("edge_count", 32'(out_word_o.edge_count), 32'(want.edge_count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    aggregate(w);
    words_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (drain_rows.size() != 0) @(posedge clk_i);
    repeat (3200) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [1:0] m);
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {30'd0, m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_mode = m;
  endtask

  function automatic in_word_t make_word(logic [1:0] c, int s, int d,
                                         logic [31:0] l0, logic [31:0] l1,
                                         logic [31:0] l2, logic [31:0] l3);
    in_word_t w;
    w.cmd = c;
    w.src_node = 10'(s);
    w.dst_node = 10'(d);
    w.lane0_in = l0;
    w.lane1_in = l1;
    w.lane2_in = l2;
    w.lane3_in = l3;
    return w;
  endfunction

  function automatic logic [31:0] rand_lane();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'hffffffff;
      3: return 32'($urandom_range(20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_node();
    if ($urandom_range(3) == 0) return $urandom_range(1023);
    return $urandom_range(15);
  endfunction

  function automatic in_word_t rand_word();
    int p;
    int s;
    p = $urandom_range(99);
    s = rand_node();
    if (p < 25 || loaded_nodes.size() == 0)
      return make_word(CMD_LOAD, s, rand_node(), rand_lane(), rand_lane(),
                       rand_lane(), rand_lane());
    s = loaded_nodes[$urandom_range(loaded_nodes.size() - 1)];
    if (p < 74)
      return make_word(CMD_EDGE, s, rand_node(), $urandom, $urandom, $urandom, $urandom);
    if (p < 99)
      return make_word(CMD_DRAIN, rand_node(), rand_node(), $urandom, $urandom,
                       $urandom, $urandom);
    return make_word(CMD_CLEAR, rand_node(), rand_node(), $urandom, $urandom,
                     $urandom, $urandom);
  endfunction

  task automatic test_directed();
    send_word(make_word(CMD_LOAD, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
    send_word(make_word(CMD_LOAD, 1023, 1023, 32'h80000000, 32'h80000000, 32'h1, 32'hffffffff));
    send_word(make_word(CMD_LOAD, 5, 0, 32'hfffffff9, 32'h7, 32'h0, 32'h3));
    send_word(make_word(CMD_DRAIN, 0, 7, '0, '0, '0, '0));
    send_word(make_word(CMD_DRAIN, 0, 1023, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 0, 3, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 0, 3, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 1023, 3, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 5, 3, '0, '0, '0, '0));
    send_word(make_word(CMD_DRAIN, 0, 3, '0, '0, '0, '0));
    set_mode(MODE_MEAN);
    send_word(make_word(CMD_DRAIN, 0, 3, '0, '0, '0, '0));
    set_mode(MODE_MIN);
    send_word(make_word(CMD_EDGE, 5, 9, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 1023, 9, '0, '0, '0, '0));
    send_word(make_word(CMD_DRAIN, 0, 9, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 0, 3, '0, '0, '0, '0));
    send_word(make_word(CMD_DRAIN, 0, 3, '0, '0, '0, '0));
    set_mode(MODE_MAX);
    send_word(make_word(CMD_EDGE, 0, 1023, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 1023, 1023, '0, '0, '0, '0));
    send_word(make_word(CMD_EDGE, 5, 1023, '0, '0, '0, '0));
    send_word(make_word(CMD_DRAIN, 0, 1023, '0, '0, '0, '0));
    send_word(make_word(CMD_CLEAR, 1023, 1023, '1, '1, '1, '1));
    send_word(make_word(CMD_DRAIN, 1023, 3, '1, '1, '1, '1));
  endtask

  task automatic test_random();
    int idle_set [4] = '{0, 62, 0, 19};
    int stall_set[4] = '{0, 0, 62, 19};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int m = 0; m < 4; m++) begin
        set_mode(2'(m));
        repeat (75) send_word(rand_word());
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_wrapping();
    set_mode(MODE_SUM);
    send_word(make_word(CMD_LOAD, 2, 0, 32'd3, 32'hfffffffd, 32'h7fffffff, 32'd1));
    repeat (40) send_word(make_word(CMD_EDGE, 2, 11, '0, '0, '0, '0));
    send_word(make_word(CMD_DRAIN, 0, 11, '0, '0, '0, '0));
    set_mode(MODE_MEAN);
    send_word(make_word(CMD_DRAIN, 0, 11, '0, '0, '0, '0));
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    repeat (20) begin
      send_word(make_word(CMD_DRAIN, 0, $urandom_range(15), '0, '0, '0, '0));
      send_word(rand_word());
    end
  endtask

  initial begin
    pool_mode = MODE_SUM;
    for (int n = 0; n < 1024; n++) begin
      edge_cnt[n] = '0;
      loaded[n] = 1'b0;
      for (int k = 0; k < 4; k++) begin
        acc_rows[n][k] = '0;
        src_rows[n][k] = '0;
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    test_backpressure();
    test_wrapping();
    settle();
    $display("Sent %0d words over all four pool modes and idle mixes, checked %0d rows.",
             words_sent, rows_checked);
    $display("Covered lane extremes, wrapping sums, min/max first copy and a long output stall.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/gsr_pkg.sv
sv/gsr_ram.sv
sv/gsr_front.sv
sv/gsr_div.sv
sv/gsr_back.sv
sv/graph_scatter_reduce_unit.sv
test/tb_top.sv
